// ----- rtl/led_blink_pattern_generator_unit_defines.svh -----
// Assertion macros used by the checker file of the LED blink unit.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef LED_BLINK_PATTERN_GENERATOR_UNIT_DEFINES_SVH
`define LED_BLINK_PATTERN_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LBPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbpg assertion failed");

// Next-cycle implication, checked outside reset.
`define LBPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbpg assertion failed");

`endif

// ----- rtl/lbpg_pkg.sv -----
// Types and constants of the LED blink pattern generator.
// No dependencies; imported by every module of the unit.
`default_nettype none

package lbpg_pkg;

  localparam int unsigned TimeBits  = 16;
  localparam int unsigned DurBits   = 16;
  localparam int unsigned CmpBits   = (TimeBits > DurBits) ? TimeBits : DurBits;
  localparam int unsigned RepBits   = 9;
  localparam int unsigned PulseBits = 8;
  localparam int unsigned PAddrBits = 5;
  localparam int unsigned PDataBits = 32;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdStart = 2'd1,
    CmdSolid = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    RegOnTime     = 3'd0,
    RegOffTime    = 3'd1,
    RegPauseTime  = 3'd2,
    RegRepeat     = 3'd3,
    RegActiveHigh = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] command;
    logic       solid_on;
  } lbpg_in_t;

  typedef struct packed {
    logic pin_level;
    logic pattern_running;
  } lbpg_out_t;

  typedef struct packed {
    logic [DurBits-1:0]        on_time_ms;
    logic [DurBits-1:0]        off_time_ms;
    logic [DurBits-1:0]        pause_time_ms;
    logic signed [RepBits-1:0] repeat_count;
    logic                      lit_high;
  } lbpg_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/lbpg_cfg_regs.sv -----
// APB register file holding the pattern configuration.
// Depends on lbpg_pkg.
`default_nettype none

module lbpg_cfg_regs
  import lbpg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PAddrBits-1:0] paddr,
  input  wire logic [PDataBits-1:0] pwdata,
  output logic      [PDataBits-1:0] prdata,
  output logic                      pready,
  output lbpg_cfg_t                 cfg_o
);

  lbpg_cfg_t cfg_q;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx    = reg_idx_e'(paddr[PAddrBits-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_time_ms    <= '0;
      cfg_q.off_time_ms   <= '0;
      cfg_q.pause_time_ms <= '0;
      cfg_q.repeat_count  <= '0;
      cfg_q.lit_high      <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        RegOnTime:     cfg_q.on_time_ms    <= pwdata[DurBits-1:0];
        RegOffTime:    cfg_q.off_time_ms   <= pwdata[DurBits-1:0];
        RegPauseTime:  cfg_q.pause_time_ms <= pwdata[DurBits-1:0];
        RegRepeat:     cfg_q.repeat_count  <= pwdata[RepBits-1:0];
        RegActiveHigh: cfg_q.lit_high      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegOnTime:     prdata = PDataBits'(cfg_q.on_time_ms);
      RegOffTime:    prdata = PDataBits'(cfg_q.off_time_ms);
      RegPauseTime:  prdata = PDataBits'(cfg_q.pause_time_ms);
      RegRepeat:     prdata = PDataBits'(unsigned'(cfg_q.repeat_count));
      RegActiveHigh: prdata = PDataBits'(cfg_q.lit_high);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lbpg_core.sv -----
// Pattern state registers and the combinational update for a single beat.
// Depends on lbpg_pkg.
`default_nettype none

module lbpg_core
  import lbpg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire lbpg_in_t  item_i,
  input  wire lbpg_cfg_t cfg_i,
  output lbpg_out_t      res_o
);

  localparam logic [TimeBits-1:0] TimeMax = '1;

  logic                 led_q, led_d;
  logic                 phase_q, phase_d;
  logic                 pausing_q, pausing_d;
  logic [PulseBits-1:0] pulse_q, pulse_d;
  logic [TimeBits-1:0]  elapsed_q, elapsed_d;
  logic [RepBits-1:0]   rep_q, rep_d;
  logic [DurBits-1:0]   on_q, on_d;
  logic [DurBits-1:0]   off_q, off_d;
  logic [DurBits-1:0]   pause_q, pause_d;

  logic [TimeBits-1:0]  el_inc;
  logic [DurBits-1:0]   dur;
  logic [PulseBits-1:0] pulse_inc;
  logic                 same_pattern;
  cmd_e                 cmd;

  assign cmd       = cmd_e'(item_i.command);
  assign el_inc    = (elapsed_q != TimeMax) ? elapsed_q + 1'b1 : elapsed_q;
  assign dur       = phase_q ? on_q : off_q;
  assign pulse_inc = pulse_q + 1'b1;
  assign same_pattern = (rep_q == unsigned'(cfg_i.repeat_count)) &&
                        (on_q == cfg_i.on_time_ms) && (off_q == cfg_i.off_time_ms) &&
                        (pause_q == cfg_i.pause_time_ms);

  always_comb begin
    led_d     = led_q;
    phase_d   = phase_q;
    pausing_d = pausing_q;
    pulse_d   = pulse_q;
    elapsed_d = elapsed_q;
    rep_d     = rep_q;
    on_d      = on_q;
    off_d     = off_q;
    pause_d   = pause_q;
    case (cmd)
      CmdTick: begin
        if (rep_q != '0) begin
          elapsed_d = el_inc;
          if (pausing_q) begin
            if (CmpBits'(el_inc) >= CmpBits'(pause_q)) begin
              pausing_d = 1'b0;
              pulse_d   = '0;
              phase_d   = 1'b1;
              elapsed_d = '0;
              led_d     = 1'b1;
            end
          end else if (CmpBits'(el_inc) >= CmpBits'(dur)) begin
            phase_d   = ~phase_q;
            led_d     = ~phase_q;
            elapsed_d = '0;
            if (phase_q) begin
              pulse_d = pulse_inc;
              if (!rep_q[RepBits-1] && (pulse_inc >= rep_q[PulseBits-1:0])) begin
                if (pause_q != '0) begin
                  pausing_d = 1'b1;
                  pulse_d   = '0;
                end else begin
                  rep_d = '0;
                  led_d = 1'b0;
                end
              end
            end
          end
        end
      end
      CmdStart: begin
        if (!same_pattern) begin
          on_d      = cfg_i.on_time_ms;
          off_d     = cfg_i.off_time_ms;
          pause_d   = cfg_i.pause_time_ms;
          rep_d     = unsigned'(cfg_i.repeat_count);
          pulse_d   = '0;
          pausing_d = 1'b0;
          phase_d   = 1'b1;
          elapsed_d = '0;
          led_d     = 1'b1;
        end
      end
      CmdSolid: begin
        rep_d     = '0;
        pausing_d = 1'b0;
        led_d     = item_i.solid_on;
      end
      default: ;
    endcase
  end

  assign res_o.pin_level       = cfg_i.lit_high ? led_d : ~led_d;
  assign res_o.pattern_running = (rep_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q     <= 1'b0;
      phase_q   <= 1'b0;
      pausing_q <= 1'b0;
      pulse_q   <= '0;
      elapsed_q <= '0;
      rep_q     <= '0;
      on_q      <= '0;
      off_q     <= '0;
      pause_q   <= '0;
    end else if (en_i) begin
      led_q     <= led_d;
      phase_q   <= phase_d;
      pausing_q <= pausing_d;
      pulse_q   <= pulse_d;
      elapsed_q <= elapsed_d;
      rep_q     <= rep_d;
      on_q      <= on_d;
      off_q     <= off_d;
      pause_q   <= pause_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/led_blink_pattern_generator_unit.sv -----
// LED blink burst pattern generator. One beat in, one beat out: each beat
// is a tick (one millisecond), a start or a solid command, and its result is
// the pin level and whether a timed pattern runs. The unit takes one beat per
// cycle while in_ready_o is high; a beat waits in the input register and its
// result moves to the output register once that one is free. While a
// result waits, the input register takes one more beat and then holds
// in_ready_o low. The pattern update is a single compare and counter step in
// lbpg_core. Configuration comes over APB (registers at byte offsets 0, 4, 8,
// 12, 16).
`default_nettype none

module led_blink_pattern_generator_unit
  import lbpg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lbpg_in_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output lbpg_out_t                 out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PAddrBits-1:0] paddr,
  input  wire logic [PDataBits-1:0] pwdata,
  output logic      [PDataBits-1:0] prdata,
  output logic                      pready
);

  lbpg_cfg_t cfg;
  lbpg_in_t  in_q;
  lbpg_out_t res;
  lbpg_out_t out_q;
  logic      in_vld_q;
  logic      out_vld_q;
  logic      advance;

  assign advance     = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o  = ~in_vld_q | advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  lbpg_cfg_regs u_regs (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  lbpg_core u_core (
    .clk_i,
    .rst_ni,
    .en_i   (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lbpg_checker.sv -----
// Port-level checks on the LED blink unit, bound to the top level.
// Depends on lbpg_pkg and led_blink_pattern_generator_unit_defines.svh.
`default_nettype none
`include "led_blink_pattern_generator_unit_defines.svh"

module lbpg_checker
  import lbpg_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire lbpg_out_t            out_data_o,
  input wire logic                 psel,
  input wire logic                 pwrite,
  input wire logic [PAddrBits-1:0] paddr,
  input wire logic [PDataBits-1:0] prdata,
  input wire logic                 pready
);

  // hold a stalled result
  `LBPG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  // input only stalls behind a stalled result
  `LBPG_ASSERT_NOW(a_in_stall, !in_ready_o, out_valid_o && !out_ready_i)
  // polarity register reads back one bit
  `LBPG_ASSERT_NOW(a_pol_read, psel && !pwrite && (paddr[PAddrBits-1:2] == RegActiveHigh),
                   prdata[PDataBits-1:1] == '0)
  `LBPG_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind led_blink_pattern_generator_unit lbpg_checker u_lbpg_checker (.*);

`default_nettype wire
